// File: hw/rtl/point_in_polygon_winding_core_assert.svh
// Assertion macros for the point-in-polygon winding core.
`ifndef POINT_IN_POLYGON_WINDING_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_WINDING_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property, ignored while reset is high.
`define PPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also evaluated during reset.
`define PPW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PPW_ASSERT(lbl, prop, msg)
`define PPW_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// File: hw/rtl/ppw_pkg.sv
// Shared constants and types for the point-in-polygon winding core.
package ppw_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = ADDR_BITS + 1;
  localparam int INDEX_BITS   = 8;
  localparam int VC_BITS      = 9;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int SUM_BITS     = PROD_BITS + 1;
  localparam int WIND_BITS    = 9;
  localparam int ACC_BITS     = CNT_BITS + 1;
  localparam int LOC_BITS     = 2;
  localparam int VERT_BITS    = 2 * COORD_BITS;

  localparam logic [VC_BITS-1:0] VC_RESET = VC_BITS'(3);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [LOC_BITS-1:0] LOC_OUTSIDE = 2'd0;
  localparam logic [LOC_BITS-1:0] LOC_INSIDE  = 2'd1;
  localparam logic [LOC_BITS-1:0] LOC_BORDER  = 2'd2;

  localparam logic signed [ACC_BITS-1:0] WIND_MAX = ACC_BITS'(255);
  localparam logic signed [ACC_BITS-1:0] WIND_MIN = -ACC_BITS'(256);

  // Controller to datapath
  typedef struct packed {
    logic                 start;
    logic                 wr_en;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 first;
    logic                 close;
    logic                 load;
  } ppw_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
    logic out_free;
  } ppw_stat_t;

endpackage

// File: hw/rtl/ppw_in_if.sv
// Input channel: vertex writes and point queries.
interface ppw_in_if import ppw_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [INDEX_BITS-1:0]        vertex_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, cmd, vertex_index, coord_x, coord_y, input ready);
  modport sink (input valid, cmd, vertex_index, coord_x, coord_y, output ready);
endinterface

// File: hw/rtl/ppw_out_if.sv
// Output channel: query results.
interface ppw_out_if import ppw_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [LOC_BITS-1:0]         location;
  logic signed [WIND_BITS-1:0] winding;

  modport source (output valid, location, winding, input ready);
  modport sink (input valid, location, winding, output ready);
endinterface

// File: hw/rtl/point_in_polygon_winding_core.sv
// Top level of the point-in-polygon winding core.
//
//   channel   dir  contents
//   query     in   cmd, vertex_index, coord_x, coord_y (valid/ready)
//   result    out  location, winding (valid/ready)
//   cfg       in   cfg_we, cfg_wdata -> vertex_count
//
// A vertex write goes into the store when accepted. A query over n vertices
// runs from acceptance to result: one RAM read per vertex, one closing edge,
// then a three-stage difference/multiply/accumulate pipeline and the result
// load. Count zero goes straight to the result load. Reset clears control
// state only; the vertex store holds garbage until written. A stalled result
// holds in the output register while the next vertex write or query is taken.
module point_in_polygon_winding_core import ppw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [VC_BITS-1:0] cfg_wdata,
  ppw_in_if.sink             query,
  ppw_out_if.source          result
);

`include "point_in_polygon_winding_core_assert.svh"

  ppw_ctl_t  ctl;
  ppw_stat_t stat;

  ppw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (query.valid),
    .in_cmd    (query.cmd),
    .in_ready  (query.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  ppw_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .vertex_index (query.vertex_index),
    .coord_x      (query.coord_x),
    .coord_y      (query.coord_y),
    .stat         (stat),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .location     (result.location),
    .winding      (result.winding)
  );

  `PPW_ASSERT(a_query_blocks, (query.valid && query.ready && query.cmd == CMD_QUERY) |=> !query.ready, "query accepted while another query runs")
  `PPW_ASSERT(a_no_rw_overlap, !(ctl.wr_en && ctl.rd_en), "vertex write during edge walk")
  `PPW_ASSERT(a_loc_matches_wind, result.valid |-> ((result.location == LOC_INSIDE) == (result.winding != 0)), "location disagrees with winding")
  `PPW_ASSERT_RST(a_reset_clears_out, rst |=> !result.valid, "result valid after reset")

endmodule

// File: hw/rtl/ppw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ppw_datapath.sv
// Vertex store, edge test pipeline, winding accumulator and result register.
module ppw_datapath import ppw_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  ppw_ctl_t                     ctl,
  input  logic [INDEX_BITS-1:0]        vertex_index,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  output ppw_stat_t                    stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LOC_BITS-1:0]          location,
  output logic signed [WIND_BITS-1:0]  winding
);

  logic [VERT_BITS-1:0] rdata;

  ppw_ram #(
    .WIDTH (VERT_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (vertex_index[ADDR_BITS-1:0]),
    .wdata ({coord_y, coord_x}),
    .re    (ctl.rd_en),
    .raddr (ctl.rd_addr),
    .rdata (rdata)
  );

  logic signed [COORD_BITS-1:0] px, py;
  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [COORD_BITS-1:0] rd_x, rd_y, b_x, b_y;

  // Tags aligned with the RAM read data
  logic t_valid, t_first, t_close;
  // Edge differences
  logic e_valid, e_close;
  logic signed [DIFF_BITS-1:0] dax, day, dbx, dby;
  // Products
  logic p_valid, p_close, p_day_pos, p_dby_pos;
  logic signed [PROD_BITS-1:0] p_ad, p_bc, p_ac, p_bd;
  // Accumulator
  logic signed [ACC_BITS-1:0] acc;
  logic border, done;

  logic signed [SUM_BITS-1:0] orient, dot;
  logic signed [ACC_BITS-1:0] acc_sat;

  assign rd_x = rdata[COORD_BITS-1:0];
  assign rd_y = rdata[VERT_BITS-1:COORD_BITS];
  // The closing edge runs back to the saved first vertex
  assign b_x  = t_close ? first_x : rd_x;
  assign b_y  = t_close ? first_y : rd_y;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      px <= coord_x;
      py <= coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      t_first <= 1'b0;
      t_close <= 1'b0;
    end else begin
      t_valid <= ctl.rd_en | ctl.close;
      t_first <= ctl.first;
      t_close <= ctl.close;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_close <= 1'b0;
    end else begin
      e_valid <= t_valid & ~t_first;
      e_close <= t_valid & t_close;
    end
  end

  always_ff @(posedge clk) begin
    if (t_valid && t_first) begin
      first_x <= rd_x;
      first_y <= rd_y;
    end
    if (t_valid && !t_close) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    dax <= DIFF_BITS'(prev_x) - DIFF_BITS'(px);
    day <= DIFF_BITS'(prev_y) - DIFF_BITS'(py);
    dbx <= DIFF_BITS'(b_x) - DIFF_BITS'(px);
    dby <= DIFF_BITS'(b_y) - DIFF_BITS'(py);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_close <= 1'b0;
    end else begin
      p_valid <= e_valid;
      p_close <= e_close;
    end
  end

  always_ff @(posedge clk) begin
    p_ad      <= dax * dby;
    p_bc      <= day * dbx;
    p_ac      <= dax * dbx;
    p_bd      <= day * dby;
    p_day_pos <= day > 0;
    p_dby_pos <= dby > 0;
  end

  // The orientation of (a,b,p) equals the cross of (a-p) and (b-p)
  assign orient = SUM_BITS'(p_ad) - SUM_BITS'(p_bc);
  assign dot    = SUM_BITS'(p_ac) + SUM_BITS'(p_bd);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      border <= 1'b0;
      done   <= 1'b0;
    end else if (ctl.start) begin
      acc    <= '0;
      border <= 1'b0;
      done   <= 1'b0;
    end else if (p_valid) begin
      if (orient == 0 && dot <= 0) begin
        border <= 1'b1;
      end
      if (orient > 0 && !p_day_pos && p_dby_pos) begin
        acc <= acc + ACC_BITS'(1);
      end else if (orient < 0 && !p_dby_pos && p_day_pos) begin
        acc <= acc - ACC_BITS'(1);
      end
      if (p_close) begin
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    if (acc > WIND_MAX) begin
      acc_sat = WIND_MAX;
    end else if (acc < WIND_MIN) begin
      acc_sat = WIND_MIN;
    end else begin
      acc_sat = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (border) begin
        location <= LOC_BORDER;
        winding  <= '0;
      end else begin
        location <= (acc_sat != 0) ? LOC_INSIDE : LOC_OUTSIDE;
        winding  <= acc_sat[WIND_BITS-1:0];
      end
    end
  end

  assign stat.done     = done;
  assign stat.out_free = ~out_valid | out_ready;

endmodule

// File: hw/rtl/ppw_ctrl.sv
// Controller: count register, input acceptance and the edge walk sequencer.
module ppw_ctrl import ppw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [VC_BITS-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  input  ppw_stat_t          stat,
  output ppw_ctl_t           ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_CLOSE  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]           state, state_next;
  logic [VC_BITS-1:0]   vertex_count;
  logic [ADDR_BITS-1:0] cnt, cnt_next;
  logic [ADDR_BITS-1:0] n_last, n_last_next;
  logic [CNT_BITS-1:0]  n_eff;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // Counts beyond the store act as a full store
  assign n_eff = (VC_BITS'(vertex_count) > VC_BITS'(MAX_VERTICES)) ?
                 CNT_BITS'(MAX_VERTICES) : CNT_BITS'(vertex_count);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    ctl.start   = accept && (in_cmd == CMD_QUERY);
    ctl.wr_en   = accept && (in_cmd == CMD_WRITE);
    ctl.rd_en   = (state == S_READ);
    ctl.rd_addr = cnt;
    ctl.first   = (state == S_READ) && (cnt == '0);
    ctl.close   = (state == S_CLOSE);
    ctl.load    = (state == S_FINISH) && stat.out_free;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    n_last_next = n_last;
    case (state)
      S_IDLE: begin
        if (ctl.start) begin
          cnt_next    = '0;
          n_last_next = ADDR_BITS'(n_eff - CNT_BITS'(1));
          state_next  = (n_eff == '0) ? S_FINISH : S_READ;
        end
      end
      S_READ: begin
        cnt_next = cnt + ADDR_BITS'(1);
        if (cnt == n_last) begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    n_last <= n_last_next;
  end

endmodule
